// File: rtl/integer_to_radix_text_macros.svh
// Assertion macros shared by the divider and datapath RTL files of the radix text converter.
`ifndef INTEGER_TO_RADIX_TEXT_MACROS_SVH
`define INTEGER_TO_RADIX_TEXT_MACROS_SVH
`ifndef ASSERT_OFF
// Same-cycle implication, checked on every rising edge outside reset.
`define I2RT_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, checked on every rising edge outside reset.
`define I2RT_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define I2RT_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define I2RT_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// File: rtl/i2rt_pkg.sv
// Package with the sizes, character codes, types and helpers of the radix text converter.
package i2rt_pkg;

  localparam int VALUE_BITS = 32;
  localparam int MAX_CHARS  = 64;

  localparam int IN_VALUE_W = 32;
  localparam int RADIX_W    = 6;
  localparam int FRAC_W     = 5;
  localparam int CHAR_W     = 7;

  localparam int EXT_BITS  = (VALUE_BITS > IN_VALUE_W) ? VALUE_BITS : IN_VALUE_W;
  localparam int COUNT_W   = $clog2(MAX_CHARS + 1);
  localparam int ADDR_W    = $clog2(MAX_CHARS);
  localparam int DIV_CNT_W = $clog2(VALUE_BITS);

  localparam logic [RADIX_W-1:0] RADIX_MIN = 6'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX = 6'd36;
  localparam logic [RADIX_W-1:0] DEC_TEN   = 6'd10;

  localparam logic [CHAR_W-1:0] CH_ZERO  = 7'h30;
  localparam logic [CHAR_W-1:0] CH_POINT = 7'h2E;
  localparam logic [CHAR_W-1:0] CH_COMMA = 7'h2C;
  localparam logic [CHAR_W-1:0] CH_MINUS = 7'h2D;
  localparam logic [CHAR_W-1:0] CH_UPPER = 7'h41;
  localparam logic [CHAR_W-1:0] CH_LOWER = 7'h61;
  localparam logic [CHAR_W-1:0] CH_ERROR = 7'h00;

  typedef enum logic [2:0] {
    SEL_ZERO,
    SEL_POINT,
    SEL_COMMA,
    SEL_DIGIT,
    SEL_MINUS
  } char_sel_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_ITER,
    ST_COMMA,
    ST_DIV,
    ST_DIGIT,
    ST_SIGN,
    ST_READ,
    ST_LOAD,
    ST_ERR
  } state_t;

  typedef struct packed {
    logic      load;
    logic      push;
    char_sel_t sel;
    logic      div_start;
    logic      advance;
    logic      rd_issue;
    logic      out_load;
    logic      out_err;
  } cmd_t;

  typedef struct packed {
    logic bad_radix;
    logic zero_case;
    logic more;
    logic need_point;
    logic need_comma;
    logic negative;
    logic div_done;
    logic out_free;
    logic rd_last;
  } stat_t;

  // ASCII character of one digit value below the radix.
  function automatic logic [CHAR_W-1:0] digit_char(input logic [RADIX_W-1:0] d,
                                                   input logic lower);
    logic [CHAR_W-1:0] base;
    base = lower ? CH_LOWER : CH_UPPER;
    if (d < DEC_TEN) begin
      return CH_ZERO + CHAR_W'(d);
    end
    return base + CHAR_W'(d - DEC_TEN);
  endfunction

endpackage

// File: rtl/i2rt_if.sv
// Valid/ready channel interfaces for the conversion requests and the output characters.
interface i2rt_in_if;
  logic                                    valid;
  logic                                    ready;
  logic signed [i2rt_pkg::IN_VALUE_W-1:0] value;
  logic        [i2rt_pkg::RADIX_W-1:0]    radix;
  logic                                    lower_case;
  logic                                    group_thousands;
  logic        [i2rt_pkg::FRAC_W-1:0]     fraction_digits;

  modport source (output valid, value, radix, lower_case, group_thousands, fraction_digits,
                  input ready);
  modport sink (input valid, value, radix, lower_case, group_thousands, fraction_digits,
                output ready);
endinterface

interface i2rt_out_if;
  logic                          valid;
  logic                          ready;
  logic [i2rt_pkg::CHAR_W-1:0]  char_code;
  logic                          last_char;
  logic                          bad_radix;

  modport source (output valid, char_code, last_char, bad_radix, input ready);
  modport sink (input valid, char_code, last_char, bad_radix, output ready);
endinterface

// File: rtl/i2rt_div.sv
// Restoring divider that produces one quotient bit per cycle for a small radix.
`include "integer_to_radix_text_macros.svh"
module i2rt_div (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic [i2rt_pkg::VALUE_BITS-1:0]   dividend,
  input  logic [i2rt_pkg::RADIX_W-1:0]      divisor,
  output logic [i2rt_pkg::VALUE_BITS-1:0]   quotient,
  output logic [i2rt_pkg::RADIX_W-1:0]      remainder,
  output logic                              done
);

  logic [i2rt_pkg::VALUE_BITS-1:0] q_r;
  logic [i2rt_pkg::RADIX_W-1:0]    rem_r;
  logic [i2rt_pkg::RADIX_W-1:0]    div_r;
  logic [i2rt_pkg::DIV_CNT_W-1:0]  cnt_r;
  logic                            busy_r;
  logic                            done_r;

  logic [i2rt_pkg::RADIX_W:0]      trial;
  logic                            fits;
  logic [i2rt_pkg::RADIX_W-1:0]    rem_nxt;

  // Bring down the next dividend bit and subtract the divisor when it fits.
  always_comb begin
    trial   = {rem_r, q_r[i2rt_pkg::VALUE_BITS-1]};
    fits    = trial >= {1'b0, div_r};
    rem_nxt = fits ? i2rt_pkg::RADIX_W'(trial - {1'b0, div_r})
                   : i2rt_pkg::RADIX_W'(trial);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
    end else if (busy_r && (cnt_r == '0)) begin
      busy_r <= 1'b0;
      done_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend;
      rem_r <= '0;
      div_r <= divisor;
      cnt_r <= i2rt_pkg::DIV_CNT_W'(i2rt_pkg::VALUE_BITS - 1);
    end else if (busy_r) begin
      q_r   <= {q_r[i2rt_pkg::VALUE_BITS-2:0], fits};
      rem_r <= rem_nxt;
      cnt_r <= cnt_r - 1'b1;
    end
  end

  assign quotient  = q_r;
  assign remainder = rem_r;
  assign done      = done_r;

  `I2RT_ASSERT_IMP(a_rem_below_div, clk, rst_n, done_r, rem_r < div_r,
                   "divider remainder is not below the divisor")
  `I2RT_ASSERT_NXT(a_start_clears_done, clk, rst_n, start, busy_r && !done_r,
                   "divider did not restart on start")

endmodule

// File: rtl/i2rt_datapath.sv
// Datapath: request fields, digit state, character store, divider and output register.
`include "integer_to_radix_text_macros.svh"
module i2rt_datapath (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  i2rt_pkg::cmd_t                          cmd,
  output i2rt_pkg::stat_t                         stat,
  input  logic signed [i2rt_pkg::IN_VALUE_W-1:0] in_value,
  input  logic        [i2rt_pkg::RADIX_W-1:0]    in_radix,
  input  logic                                    in_lower_case,
  input  logic                                    in_group_thousands,
  input  logic        [i2rt_pkg::FRAC_W-1:0]     in_fraction_digits,
  input  logic                                    out_ready,
  output logic                                    out_valid,
  output logic        [i2rt_pkg::CHAR_W-1:0]     out_char_code,
  output logic                                    out_last_char,
  output logic                                    out_bad_radix
);

  // Request fields and conversion state.
  logic [i2rt_pkg::RADIX_W-1:0]    radix_r;
  logic                            lower_r;
  logic                            group_r;
  logic                            bad_r;
  logic                            neg_r;
  logic [i2rt_pkg::VALUE_BITS-1:0] mag_r;
  logic [i2rt_pkg::FRAC_W-1:0]     fcnt_r;
  logic                            fpos_r;
  logic                            before_r;
  logic [1:0]                      grp_phase_r;
  logic                            int_seen_r;
  logic [i2rt_pkg::COUNT_W-1:0]    char_count_r;

  // Character store and read-out.
  logic [i2rt_pkg::CHAR_W-1:0]     store [i2rt_pkg::MAX_CHARS];
  logic [i2rt_pkg::CHAR_W-1:0]     rd_data_r;
  logic                            rd_last_r;

  // Output register.
  logic                            out_valid_r;
  logic [i2rt_pkg::CHAR_W-1:0]     out_char_r;
  logic                            out_last_r;
  logic                            out_bad_r;

  logic [i2rt_pkg::EXT_BITS-1:0]   ext_value;
  logic [i2rt_pkg::VALUE_BITS-1:0] narrow_value;
  logic                            in_neg;
  logic [i2rt_pkg::VALUE_BITS-1:0] in_mag;
  logic [i2rt_pkg::VALUE_BITS-1:0] quotient;
  logic [i2rt_pkg::RADIX_W-1:0]    remainder;
  logic                            div_done;
  logic [i2rt_pkg::CHAR_W-1:0]     push_char;
  logic                            can_push;
  logic [i2rt_pkg::COUNT_W-1:0]    rd_index;

  i2rt_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (cmd.div_start),
    .dividend  (mag_r),
    .divisor   (radix_r),
    .quotient  (quotient),
    .remainder (remainder),
    .done      (div_done)
  );

  // Sign-extend, wrap to the working width and take an unsigned magnitude.
  always_comb begin
    ext_value    = i2rt_pkg::EXT_BITS'(in_value);
    narrow_value = ext_value[i2rt_pkg::VALUE_BITS-1:0];
    in_neg       = narrow_value[i2rt_pkg::VALUE_BITS-1];
    in_mag       = in_neg ? ((~narrow_value) + {{(i2rt_pkg::VALUE_BITS-1){1'b0}}, 1'b1})
                          : narrow_value;
  end

  always_comb begin
    case (cmd.sel)
      i2rt_pkg::SEL_ZERO:  push_char = i2rt_pkg::CH_ZERO;
      i2rt_pkg::SEL_POINT: push_char = i2rt_pkg::CH_POINT;
      i2rt_pkg::SEL_COMMA: push_char = i2rt_pkg::CH_COMMA;
      i2rt_pkg::SEL_DIGIT: push_char = i2rt_pkg::digit_char(remainder, lower_r);
      i2rt_pkg::SEL_MINUS: push_char = i2rt_pkg::CH_MINUS;
      default:             push_char = i2rt_pkg::CH_ERROR;
    endcase
  end

  assign can_push = char_count_r < i2rt_pkg::COUNT_W'(i2rt_pkg::MAX_CHARS);
  assign rd_index = char_count_r - 1'b1;

  always_comb begin
    stat.bad_radix  = bad_r;
    stat.zero_case  = (mag_r == '0) && (fcnt_r == '0);
    stat.more       = (mag_r != '0) || fpos_r;
    stat.need_point = fpos_r && (fcnt_r == '0) && !before_r;
    stat.need_comma = group_r && before_r && int_seen_r && (grp_phase_r == 2'd0);
    stat.negative   = neg_r;
    stat.div_done   = div_done;
    stat.out_free   = !out_valid_r || out_ready;
    stat.rd_last    = rd_last_r;
  end

  // Request fields and digit bookkeeping.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      radix_r     <= in_radix;
      lower_r     <= in_lower_case;
      group_r     <= in_group_thousands;
      bad_r       <= (in_radix < i2rt_pkg::RADIX_MIN) || (in_radix > i2rt_pkg::RADIX_MAX);
      neg_r       <= in_neg;
      mag_r       <= in_mag;
      fcnt_r      <= in_fraction_digits;
      fpos_r      <= 1'b1;
      before_r    <= (in_fraction_digits == '0);
      grp_phase_r <= 2'd0;
      int_seen_r  <= 1'b0;
    end else begin
      if (cmd.push && (cmd.sel == i2rt_pkg::SEL_POINT)) begin
        before_r <= 1'b1;
      end
      if (cmd.advance) begin
        mag_r <= quotient;
        if (fpos_r) begin
          if (fcnt_r == '0) begin
            fpos_r <= 1'b0;
          end else begin
            fcnt_r <= fcnt_r - 1'b1;
          end
        end
        if (before_r) begin
          int_seen_r  <= 1'b1;
          grp_phase_r <= (grp_phase_r == 2'd2) ? 2'd0 : grp_phase_r + 1'b1;
        end
      end
    end
  end

  // Fill count: grows on each stored character, shrinks on each read-back.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      char_count_r <= '0;
    end else if (cmd.load) begin
      char_count_r <= '0;
    end else if (cmd.push && can_push) begin
      char_count_r <= char_count_r + 1'b1;
    end else if (cmd.rd_issue) begin
      char_count_r <= rd_index;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push && can_push) begin
      store[char_count_r[i2rt_pkg::ADDR_W-1:0]] <= push_char;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_issue) begin
      rd_data_r <= store[rd_index[i2rt_pkg::ADDR_W-1:0]];
      rd_last_r <= (char_count_r == i2rt_pkg::COUNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load || cmd.out_err) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_err) begin
      out_char_r <= i2rt_pkg::CH_ERROR;
      out_last_r <= 1'b1;
      out_bad_r  <= 1'b1;
    end else if (cmd.out_load) begin
      out_char_r <= rd_data_r;
      out_last_r <= rd_last_r;
      out_bad_r  <= 1'b0;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_char_code = out_char_r;
  assign out_last_char = out_last_r;
  assign out_bad_radix = out_bad_r;

  `I2RT_ASSERT_IMP(a_err_shape, clk, rst_n, out_valid_r && out_bad_r,
                   out_last_r && (out_char_r == i2rt_pkg::CH_ERROR),
                   "error result is not a single zero character")
  `I2RT_ASSERT_IMP(a_digit_after_div, clk, rst_n, cmd.advance, div_done,
                   "digit taken before the division finished")
  `I2RT_ASSERT_IMP(a_read_nonempty, clk, rst_n, cmd.rd_issue, char_count_r != '0,
                   "read-back from an empty character store")

endmodule

// File: rtl/i2rt_ctrl.sv
// Controller state machine that sequences digit extraction and character read-back.
module i2rt_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  i2rt_pkg::stat_t stat,
  output i2rt_pkg::cmd_t  cmd
);

  i2rt_pkg::state_t state_r;
  i2rt_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= i2rt_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    in_ready      = 1'b0;
    cmd.load      = 1'b0;
    cmd.push      = 1'b0;
    cmd.sel       = i2rt_pkg::SEL_DIGIT;
    cmd.div_start = 1'b0;
    cmd.advance   = 1'b0;
    cmd.rd_issue  = 1'b0;
    cmd.out_load  = 1'b0;
    cmd.out_err   = 1'b0;
    case (state_r)
      i2rt_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = i2rt_pkg::ST_CHECK;
        end
      end
      i2rt_pkg::ST_CHECK: begin
        if (stat.bad_radix) begin
          state_nxt = i2rt_pkg::ST_ERR;
        end else if (stat.zero_case) begin
          cmd.push  = 1'b1;
          cmd.sel   = i2rt_pkg::SEL_ZERO;
          state_nxt = i2rt_pkg::ST_READ;
        end else begin
          state_nxt = i2rt_pkg::ST_ITER;
        end
      end
      i2rt_pkg::ST_ITER: begin
        if (!stat.more) begin
          state_nxt = i2rt_pkg::ST_SIGN;
        end else begin
          if (stat.need_point) begin
            cmd.push = 1'b1;
            cmd.sel  = i2rt_pkg::SEL_POINT;
          end
          state_nxt = i2rt_pkg::ST_COMMA;
        end
      end
      i2rt_pkg::ST_COMMA: begin
        if (stat.need_comma) begin
          cmd.push = 1'b1;
          cmd.sel  = i2rt_pkg::SEL_COMMA;
        end
        cmd.div_start = 1'b1;
        state_nxt     = i2rt_pkg::ST_DIV;
      end
      i2rt_pkg::ST_DIV: begin
        if (stat.div_done) begin
          state_nxt = i2rt_pkg::ST_DIGIT;
        end
      end
      i2rt_pkg::ST_DIGIT: begin
        cmd.push    = 1'b1;
        cmd.sel     = i2rt_pkg::SEL_DIGIT;
        cmd.advance = 1'b1;
        state_nxt   = i2rt_pkg::ST_ITER;
      end
      i2rt_pkg::ST_SIGN: begin
        if (stat.negative) begin
          cmd.push = 1'b1;
          cmd.sel  = i2rt_pkg::SEL_MINUS;
        end
        state_nxt = i2rt_pkg::ST_READ;
      end
      i2rt_pkg::ST_READ: begin
        cmd.rd_issue = 1'b1;
        state_nxt    = i2rt_pkg::ST_LOAD;
      end
      i2rt_pkg::ST_LOAD: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = stat.rd_last ? i2rt_pkg::ST_IDLE : i2rt_pkg::ST_READ;
        end
      end
      i2rt_pkg::ST_ERR: begin
        if (stat.out_free) begin
          cmd.out_err = 1'b1;
          state_nxt   = i2rt_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = i2rt_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// File: rtl/integer_to_radix_text.sv
// Top level of the integer to radix text converter: controller plus datapath.
//
//   Channel   Direction  Handshake      Payload
//   in_if     sink       valid / ready  value, radix, lower_case, group_thousands,
//                                       fraction_digits
//   out_if    source     valid / ready  char_code, last_char, bad_radix
//
// Each digit passes through the bit-serial divider, which shares one subtractor across
// all digits; each output character passes through the store read and the output
// register load.
// Reset is synchronous and active low; it idles the controller, empties the store
// and drops the output valid. The character store holds no reset value.
// A stalled output only holds read-back and the error result; a new request is taken as
// soon as the last character of the previous one sits in the output register.
module integer_to_radix_text (
  input  logic        clk,
  input  logic        rst_n,
  i2rt_in_if.sink     in_if,
  i2rt_out_if.source  out_if
);

  i2rt_pkg::cmd_t  cmd;
  i2rt_pkg::stat_t stat;
  logic            in_ready;

  // The controller only sequences; every value lives in the datapath.
  i2rt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_if.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // The datapath holds the request fields, the digit state, the character store
  // and the output register that separates read-back from the downstream stall.
  i2rt_datapath u_datapath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .stat               (stat),
    .in_value           (in_if.value),
    .in_radix           (in_if.radix),
    .in_lower_case      (in_if.lower_case),
    .in_group_thousands (in_if.group_thousands),
    .in_fraction_digits (in_if.fraction_digits),
    .out_ready          (out_if.ready),
    .out_valid          (out_if.valid),
    .out_char_code      (out_if.char_code),
    .out_last_char      (out_if.last_char),
    .out_bad_radix      (out_if.bad_radix)
  );

  assign in_if.ready = in_ready;

endmodule
